// ----- rtl/ray_segment_box_entry_defines.svh -----
// ---------------------------------------------------------------------------
// ray_segment_box_entry_defines
// Assertion macros shared by the ray segment / box entry RTL.
// ---------------------------------------------------------------------------
`ifndef RAY_SEGMENT_BOX_ENTRY_DEFINES_SVH
`define RAY_SEGMENT_BOX_ENTRY_DEFINES_SVH

// same-cycle implication
`define RSBE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rsbe_pkg.sv -----
// ---------------------------------------------------------------------------
// rsbe_pkg
// Shared constants of the ray segment / box entry block.
// ---------------------------------------------------------------------------
package rsbe_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int N_AXES         = 3;
    localparam int N_DIV          = 2 * N_AXES;
    localparam int N_IN_FIELDS    = 4 * N_AXES;

endpackage

// ----- rtl/ray_segment_box_entry.sv -----
// ---------------------------------------------------------------------------
// ray_segment_box_entry
// Slab test of a ray segment against an axis-aligned box, fully pipelined.
// ---------------------------------------------------------------------------
// One item per cycle in, one result per item out, unless the output stalls. Stages in
// order: a pre-stage register forms the corner differences and the overflow check,
// the divider stages run six restoring dividers one quotient bit per stage, then
// saturate/order, reduce, and the output register. A stall on the output freezes
// the whole pipeline; nothing is dropped.
// ---------------------------------------------------------------------------
`include "ray_segment_box_entry_defines.svh"

module ray_segment_box_entry #(
    parameter int COORD_BITS = rsbe_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rsbe_pkg::FRAC_BITS_DEF,
    localparam int IN_W      = ((rsbe_pkg::N_IN_FIELDS * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((FRAC_BITS + 1 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // origin_x/y/z, dir_x/y/z, box_a_x/y/z, box_b_x/y/z from the low bits up
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // entry_t, zero padded
    output logic [OUT_W-1:0] o_m_axis_tdata,
    // hit
    output logic             o_m_axis_tuser
);

    localparam int CB   = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int NA   = rsbe_pkg::N_AXES;
    localparam int ND   = rsbe_pkg::N_DIV;
    localparam int NW   = CB + 1 + F;
    localparam int CW   = 2 * CB + F + 1;
    localparam int TW   = CB + F + 2;
    localparam int NSTG = CB;

    localparam logic [CB-1:0] LIM_POS = CB'((64'd1 << (CB - 1)) - 64'd1);
    localparam logic [CB-1:0] LIM_NEG = CB'(64'd1 << (CB - 1));
    localparam logic signed [TW-1:0] ONE_T = TW'(64'd1 << F);

    logic en;

    // divider pipeline, stage 0 is the pre-stage register
    logic              r_vld  [0:NSTG];
    logic [CB-1:0]     r_rem  [0:NSTG][0:ND-1];
    logic [CB-1:0]     r_nlo  [0:NSTG][0:ND-1];
    logic [CB-1:0]     r_q    [0:NSTG][0:ND-1];
    logic [CB-1:0]     r_dmag [0:NSTG][0:ND-1];
    logic              r_neg  [0:NSTG][0:ND-1];
    logic              r_ovf  [0:NSTG][0:ND-1];
    logic [NA-1:0]     r_zax  [0:NSTG];
    logic              r_zmiss[0:NSTG];

    logic                    r_vld_o;
    logic signed [TW-1:0]    r_near [0:NA-1];
    logic signed [TW-1:0]    r_far  [0:NA-1];
    logic                    r_miss_o;
    logic                    r_vld_r;
    logic signed [TW-1:0]    r_lo;
    logic signed [TW-1:0]    r_hi;
    logic                    r_miss_r;
    logic                    r_out_vld;
    logic                    r_hit;
    logic [F:0]              r_entry;

    assign en              = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // ---------------- pre-stage ----------------
    logic [CB:0]   n_mag  [0:ND-1];
    logic          n_nneg [0:ND-1];
    logic [CB-1:0] n_dmag [0:NA-1];
    logic          n_dneg [0:NA-1];
    logic [NA-1:0] n_zax;
    logic          n_zmiss;

    always_comb begin
        logic signed [CB-1:0] o, d, c;
        logic signed [CB:0]   df;
        n_zmiss = 1'b0;
        for (int ax = 0; ax < NA; ax++) begin
            o = i_s_axis_tdata[ax*CB +: CB];
            d = i_s_axis_tdata[(NA+ax)*CB +: CB];
            n_dneg[ax] = d[CB-1];
            n_dmag[ax] = d[CB-1] ? CB'(-d) : CB'(d);
            n_zax[ax]  = (d == '0);
            for (int k = 0; k < 2; k++) begin
                c  = i_s_axis_tdata[((2+k)*NA+ax)*CB +: CB];
                df = (CB+1)'(c) - (CB+1)'(o);
                n_nneg[2*ax+k] = df[CB];
                n_mag[2*ax+k]  = df[CB] ? (CB+1)'(-df) : (CB+1)'(df);
            end
            if (n_zax[ax] && n_mag[2*ax] != '0 && n_mag[2*ax+1] != '0
                && n_nneg[2*ax] == n_nneg[2*ax+1]) begin
                n_zmiss = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NW-1:0] num;
        logic [CW-1:0] nsh;
        if (en) begin
            r_zax[0]   <= n_zax;
            r_zmiss[0] <= n_zmiss;
            for (int k = 0; k < ND; k++) begin
                num = {n_mag[k], {F{1'b0}}};
                nsh = CW'(num) >> CB;
                r_rem[0][k]  <= nsh[CB-1:0];
                r_nlo[0][k]  <= num[CB-1:0];
                r_q[0][k]    <= '0;
                r_dmag[0][k] <= n_dmag[k/2];
                r_neg[0][k]  <= n_nneg[k] ^ n_dneg[k/2];
                r_ovf[0][k]  <= (CW'(num) >= (CW'(n_dmag[k/2]) << CB));
            end
        end
    end

    // ---------------- restoring divider stages ----------------
    for (genvar s = 1; s <= NSTG; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            logic [CB:0] t;
            logic        ge;
            if (en) begin
                r_zax[s]   <= r_zax[s-1];
                r_zmiss[s] <= r_zmiss[s-1];
                for (int k = 0; k < ND; k++) begin
                    t  = {r_rem[s-1][k], r_nlo[s-1][k][CB-1]};
                    ge = (t >= {1'b0, r_dmag[s-1][k]});
                    r_rem[s][k]  <= ge ? CB'(t - {1'b0, r_dmag[s-1][k]}) : t[CB-1:0];
                    r_nlo[s][k]  <= r_nlo[s-1][k] << 1;
                    r_q[s][k]    <= {r_q[s-1][k][CB-2:0], ge};
                    r_dmag[s][k] <= r_dmag[s-1][k];
                    r_neg[s][k]  <= r_neg[s-1][k];
                    r_ovf[s][k]  <= r_ovf[s-1][k];
                end
            end
        end
    end

    // ---------------- saturate and order ----------------
    logic signed [TW-1:0] n_t [0:ND-1];

    always_comb begin
        logic [CB-1:0] lim, mag;
        for (int k = 0; k < ND; k++) begin
            lim = r_neg[NSTG][k] ? LIM_NEG : LIM_POS;
            if (r_ovf[NSTG][k] || r_q[NSTG][k] > lim) begin
                mag = lim;
            end else begin
                mag = r_q[NSTG][k];
            end
            if (r_zax[NSTG][k/2]) begin
                n_t[k] = (k % 2 == 1) ? ONE_T : '0;
            end else if (r_neg[NSTG][k]) begin
                n_t[k] = -$signed(TW'(mag));
            end else begin
                n_t[k] = $signed(TW'(mag));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
            r_vld_r <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld_o <= r_vld[NSTG];
            r_vld_r <= r_vld_o;
            r_out_vld <= r_vld_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_miss_o <= r_zmiss[NSTG];
            for (int ax = 0; ax < NA; ax++) begin
                if (n_t[2*ax] < n_t[2*ax+1]) begin
                    r_near[ax] <= n_t[2*ax];
                    r_far[ax]  <= n_t[2*ax+1];
                end else begin
                    r_near[ax] <= n_t[2*ax+1];
                    r_far[ax]  <= n_t[2*ax];
                end
            end
        end
    end

    // ---------------- reduce ----------------
    always_ff @(posedge i_clk) begin
        logic signed [TW-1:0] lo, hi;
        if (en) begin
            lo = '0;
            hi = ONE_T;
            for (int ax = 0; ax < NA; ax++) begin
                if (r_near[ax] > lo) lo = r_near[ax];
                if (r_far[ax] < hi)  hi = r_far[ax];
            end
            r_lo     <= lo;
            r_hi     <= hi;
            r_miss_r <= r_miss_o;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_miss_r || r_lo > r_hi) begin
                r_hit   <= 1'b0;
                r_entry <= '0;
            end else begin
                r_hit   <= 1'b1;
                r_entry <= r_lo[F:0];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_W'(r_entry);
    assign o_m_axis_tuser  = r_hit;

    // ---------------- assertions ----------------
    `RSBE_ASSERT_NOW(a_miss_zero, o_m_axis_tvalid && !o_m_axis_tuser, r_entry == '0,
        "miss with nonzero entry")
    `RSBE_ASSERT_NOW(a_entry_range, o_m_axis_tvalid, r_entry <= ONE_T[F:0],
        "entry above 1.0")
    `RSBE_ASSERT_NEXT(a_stall_keep, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(r_entry) && $stable(r_hit),
        "result lost under stall")

endmodule

// ----- sim/ray_segment_box_entry_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ray_segment_box_entry_checker
// Watches both streams of the segment/box entry block, computes the slab
// result of every accepted item and compares each output transfer in order.
// ---------------------------------------------------------------------------
module ray_segment_box_entry_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [383:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [23:0]  i_m_tdata,
    input  logic         i_m_tuser,
    output int           o_errors,
    output int           o_pending
);
    localparam longint ONE_T   = 64'sd65536;
    localparam longint POS_LIM = 64'sd2147483647;
    localparam longint NEG_LIM = 64'sd2147483648;

    typedef struct packed {
        logic        hit;
        logic [16:0] entry_t;
    } slab_result_t;

    slab_result_t hit_queue[$];

    // saturated, truncated num * 2^16 / den
    function automatic longint slab_quotient(longint num, longint den);
        logic   neg;
        longint nmag;
        longint dmag;
        longint q;
        longint lim;
        neg  = (num < 0) != (den < 0);
        nmag = num < 0 ? -num : num;
        dmag = den < 0 ? -den : den;
        lim  = neg ? NEG_LIM : POS_LIM;
        if ((nmag / dmag) > (lim >>> 16)) begin
            q = lim;
        end else begin
            q = ((nmag / dmag) << 16) | (((nmag % dmag) << 16) / dmag);
            if (q > lim)
                q = lim;
        end
        return neg ? -q : q;
    endfunction

    function automatic slab_result_t slab_entry(logic [383:0] item);
        longint lo;
        longint hi;
        longint o;
        longint d;
        longint ca;
        longint cb;
        longint t0;
        longint t1;
        logic   miss;
        slab_result_t r;
        lo   = 0;
        hi   = ONE_T;
        miss = 1'b0;
        for (int ax = 0; ax < 3; ax++) begin
            o  = longint'($signed(item[32*ax +: 32]));
            d  = longint'($signed(item[32*(3+ax) +: 32]));
            ca = longint'($signed(item[32*(6+ax) +: 32])) - o;
            cb = longint'($signed(item[32*(9+ax) +: 32])) - o;
            if (d == 0) begin
                if (ca != 0 && cb != 0 && ((ca < 0) == (cb < 0)))
                    miss = 1'b1;
                t0 = 0;
                t1 = ONE_T;
            end else begin
                t0 = slab_quotient(ca, d);
                t1 = slab_quotient(cb, d);
            end
            if ((t0 < t1 ? t0 : t1) > lo)
                lo = t0 < t1 ? t0 : t1;
            if ((t0 < t1 ? t1 : t0) < hi)
                hi = t0 < t1 ? t1 : t0;
        end
        if (miss || lo > hi) begin
            r = '0;
        end else begin
            r.hit     = 1'b1;
            r.entry_t = lo[16:0];
        end
        return r;
    endfunction

    assign o_pending = hit_queue.size();

    always @(posedge i_clk) begin
        slab_result_t want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                hit_queue.push_back(slab_entry(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (hit_queue.size() == 0) begin
                    $display("%0t: unexpected transfer hit=%0d entry_t=%0d", $time,
                             i_m_tuser, i_m_tdata[16:0]);
                    o_errors <= o_errors + 1;
                end else begin
                    want = hit_queue.pop_front();
                    if (want.hit !== i_m_tuser || want.entry_t !== i_m_tdata[16:0]
                            || i_m_tdata[23:17] !== 7'd0) begin
                        $display("%0t: expected hit=%0d entry_t=%0d, got hit=%0d tdata=%0h",
                                 $time, want.hit, want.entry_t, i_m_tuser, i_m_tdata);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- sim/tb_ray_segment_box_entry.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ray_segment_box_entry
// Drives directed and random segment/box items with random gaps and output
// stalls; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_ray_segment_box_entry;
    localparam int N_RANDOM = 630;
    localparam int WATCHDOG = 2000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [383:0] s_tdata = '0;    // origin_x/y/z, dir_x/y/z, box_a_x/y/z, box_b_x/y/z
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;         // entry_t, zero padded
    logic         m_tuser;         // hit
    int           errors;
    int           pending;
    int           idle_cycles = 0;
    logic         stim_done = 1'b0;
    logic         m_xfer = 1'b0;
    int           m_wait = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    ray_segment_box_entry dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    ray_segment_box_entry_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            3: return $urandom_range(0, 2) == 0 ? 32'd0 : 32'($signed($urandom_range(0, 8)) - 4);
            default: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
        endcase
    endfunction

    // mostly segments aimed through small boxes near the origin
    function automatic logic [383:0] rand_segment();
        logic [383:0] v;
        int           c;
        for (int ax = 0; ax < 3; ax++) begin
            if ($urandom_range(0, 3) == 0) begin
                for (int f = 0; f < 4; f++)
                    v[32*(3*f+ax) +: 32] = rand_coord();
            end else begin
                c = $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
                v[32*ax +: 32]     = 32'(c - $signed($urandom_range(0, 4 * 65536)));
                v[32*(3+ax) +: 32] = $urandom_range(0, 7) == 0 ? 32'd0
                                     : 32'($signed($urandom_range(0, 16 * 65536)) - 4 * 65536);
                v[32*(6+ax) +: 32] = 32'(c - $signed($urandom_range(0, 65536)));
                v[32*(9+ax) +: 32] = 32'(c + $signed($urandom_range(0, 65536)));
            end
        end
        return v;
    endfunction

    task automatic send_item(logic [383:0] v);
        repeat ($urandom_range(0, 11)) @(negedge i_clk);
        s_tdata  <= v;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [383:0] pack_axes(logic [31:0] o, logic [31:0] d,
                                               logic [31:0] a, logic [31:0] b);
        return {{3{b}}, {3{a}}, {3{d}}, {3{o}}};
    endfunction

    // output side may drop tready for a random wait after each transfer
    always @(posedge i_clk) begin
        m_xfer <= m_tvalid && m_tready;
    end

    always @(negedge i_clk) begin
        int w;
        if (i_rst_n) begin
            if (m_xfer) begin
                w = $urandom_range(0, 11);
                m_wait   <= w;
                m_tready <= (w == 0);
            end else if (m_wait > 0) begin
                m_wait   <= m_wait - 1;
                m_tready <= (m_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [383:0] v;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // hits, misses, zero directions inside/outside/on boundary, extremes
        send_item(pack_axes(32'd0, 32'h0001_0000, 32'h0000_8000, 32'h0001_8000));
        send_item(pack_axes(32'd0, 32'hffff_0000, 32'hffff_8000, 32'hfffe_8000));
        send_item(pack_axes(32'd0, 32'd0, 32'hffff_0000, 32'h0001_0000));
        send_item(pack_axes(32'd0, 32'd0, 32'h0001_0000, 32'h0002_0000));
        send_item(pack_axes(32'd0, 32'd0, 32'd0, 32'h0002_0000));
        send_item(pack_axes(32'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        send_item(pack_axes(32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'h8000_0000));
        send_item(pack_axes(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
        send_item(pack_axes(32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'd0));
        send_item(pack_axes(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        send_item(pack_axes(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        send_item(pack_axes(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        send_item('0);
        send_item('1);
        for (int k = 0; k < N_RANDOM; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                for (int f = 0; f < 12; f++)
                    v[32*f +: 32] = rand_coord();
                send_item(v);
            end else begin
                send_item(rand_segment());
            end
        end
        stim_done <= 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
